[hdl/fie_pkg.sv]
package fie_pkg;

  localparam int PRICE_W  = 24;
  localparam int VOL_W    = 24;
  localparam int DIFF_W   = PRICE_W + 1;
  localparam int FORCE_W  = 49;
  localparam int ALPHA_W  = 17;
  localparam int DELTA_W  = FORCE_W + 1;
  localparam int PROD_W   = DELTA_W + ALPHA_W + 1;
  localparam int FRAC_W   = 16;
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd9362;

  // register index taken from the word address
  localparam logic REG_SMOOTHING = 1'b0;

  typedef enum logic [1:0] {
    PH_FIRST,
    PH_SEED,
    PH_RUN
  } phase_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_RAW,
    B_SCALE,
    B_ACC,
    B_OUT
  } back_state_e;

  // one queued transaction: the seed flag, price change and volume
  typedef struct packed {
    logic                     seed;
    logic signed [DIFF_W-1:0] diff;
    logic [VOL_W-1:0]         volume;
  } fie_entry_t;

  typedef struct packed {
    logic full;
    logic valid;
  } fie_qstat_t;

endpackage

[hdl/fie_if.sv]
interface fie_in_if;
  logic                          valid;
  logic                          ready;
  logic [fie_pkg::PRICE_W-1:0]   close_price;
  logic [fie_pkg::VOL_W-1:0]     trade_volume;
  logic                          last_of_series;

  modport source (output valid, close_price, trade_volume, last_of_series, input ready);
  modport sink   (input valid, close_price, trade_volume, last_of_series, output ready);
endinterface

interface fie_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [fie_pkg::FORCE_W-1:0] force_index;

  modport source (output valid, force_index, input ready);
  modport sink   (input valid, force_index, output ready);
endinterface

[hdl/force_index_ema_unit.sv]
// Force index with EMA smoothing.
// The back end takes one queued item at a time through the states RAW, SCALE, ACC (smoothed
// items only) and OUT, and pops the next item only after its result has been taken.
// The first item of a series gives no result and only updates the stored close.
// Reset (async, active low): series restarts, stored close and average clear, alpha 9362.
module force_index_ema_unit (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  fie_in_if.sink                       in_i,
  fie_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fie_pkg::APB_AW-1:0]   paddr,
  input  logic [fie_pkg::APB_DW-1:0]   pwdata,
  output logic [fie_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import fie_pkg::*;

  logic [ALPHA_W-1:0] alpha_q, alpha_d;
  logic               cfg_wr;
  logic               push;
  fie_entry_t         push_data;
  fie_entry_t         head;
  fie_qstat_t         stat;
  logic               pop;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    alpha_d = alpha_q;
    if (cfg_wr && paddr[2] == REG_SMOOTHING) begin
      alpha_d = pwdata[ALPHA_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
    end else begin
      alpha_q <= alpha_d;
    end
  end

  assign prdata = (paddr[2] == REG_SMOOTHING) ? {{(APB_DW-ALPHA_W){1'b0}}, alpha_q} : '0;

  fie_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .stat_i      (stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  fie_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (stat)
  );

  fie_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head),
    .stat_i  (stat),
    .alpha_i (alpha_q),
    .pop_o   (pop),
    .out_o   (out_o)
  );
endmodule

[hdl/fie_queue.sv]
module fie_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fie_pkg::fie_entry_t push_data_i,
  input  logic                pop_i,
  output fie_pkg::fie_entry_t head_o,
  output fie_pkg::fie_qstat_t stat_o
);
  import fie_pkg::*;

  fie_entry_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign do_push = push_i && (count_q != 2'd2);
  assign do_pop  = pop_i && (count_q != 2'd0);

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.valid = (count_q != 2'd0);
endmodule

[hdl/fie_front.sv]
module fie_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  fie_in_if.sink              in_i,
  input  fie_pkg::fie_qstat_t stat_i,
  output logic                push_o,
  output fie_pkg::fie_entry_t push_data_o
);
  import fie_pkg::*;

  phase_e             phase_q, phase_d;
  logic [PRICE_W-1:0] prev_close_q, prev_close_d;
  logic               accept;

  assign in_i.ready = !stat_i.full;
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    phase_d      = phase_q;
    prev_close_d = prev_close_q;
    if (accept) begin
      prev_close_d = in_i.close_price;
      unique case (phase_q)
        PH_FIRST: phase_d = PH_SEED;
        PH_SEED:  phase_d = PH_RUN;
        PH_RUN:   phase_d = PH_RUN;
        default:  phase_d = PH_RUN;
      endcase
      if (in_i.last_of_series) begin
        phase_d = PH_FIRST;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_FIRST;
      prev_close_q <= '0;
    end else begin
      phase_q      <= phase_d;
      prev_close_q <= prev_close_d;
    end
  end

  // first item of a series only updates the stored close
  assign push_o             = accept && (phase_q != PH_FIRST);
  assign push_data_o.seed   = (phase_q == PH_SEED);
  assign push_data_o.diff   = $signed({1'b0, in_i.close_price}) - $signed({1'b0, prev_close_q});
  assign push_data_o.volume = in_i.trade_volume;
endmodule

[hdl/fie_back.sv]
module fie_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  fie_pkg::fie_entry_t         head_i,
  input  fie_pkg::fie_qstat_t         stat_i,
  input  logic [fie_pkg::ALPHA_W-1:0] alpha_i,
  output logic                        pop_o,
  fie_out_if.source                   out_o
);
  import fie_pkg::*;

  back_state_e               state_q, state_d;
  logic                      seed_q;
  logic signed [DIFF_W-1:0]  diff_q;
  logic [VOL_W-1:0]          vol_q;
  logic signed [FORCE_W-1:0] raw_q, raw_d;
  logic signed [PROD_W-1:0]  prod_q, prod_d;
  logic signed [FORCE_W-1:0] ema_q, ema_d;

  logic signed [DIFF_W+VOL_W:0]     raw_full;
  logic signed [DELTA_W-1:0]        delta;
  logic [ALPHA_W-1:0]               alpha_sat;
  logic signed [PROD_W-FRAC_W-1:0]  scaled;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      B_IDLE:  if (stat_i.valid) state_d = B_RAW;
      B_RAW:   state_d = B_SCALE;
      B_SCALE: state_d = seed_q ? B_OUT : B_ACC;
      B_ACC:   state_d = B_OUT;
      B_OUT:   if (out_o.ready) state_d = B_IDLE;
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o       = (state_q == B_IDLE) && stat_i.valid;
    out_o.valid = (state_q == B_OUT);
  end

  // datapath: raw product, then scaled difference, then accumulate
  always_comb begin
    raw_full  = $signed({1'b0, vol_q}) * diff_q;
    raw_d     = raw_full[FORCE_W-1:0];
    alpha_sat = (alpha_i > ALPHA_ONE) ? ALPHA_ONE : alpha_i;
    delta     = {raw_q[FORCE_W-1], raw_q} - {ema_q[FORCE_W-1], ema_q};
    prod_d    = delta * $signed({1'b0, alpha_sat});
    scaled    = prod_q[PROD_W-1:FRAC_W];
    ema_d     = ema_q;
    if (state_q == B_SCALE && seed_q) begin
      ema_d = raw_q;
    end else if (state_q == B_ACC) begin
      ema_d = ema_q + scaled[FORCE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      ema_q   <= '0;
    end else begin
      state_q <= state_d;
      ema_q   <= ema_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      seed_q <= head_i.seed;
      diff_q <= head_i.diff;
      vol_q  <= head_i.volume;
    end
    if (state_q == B_RAW) begin
      raw_q <= raw_d;
    end
    if (state_q == B_SCALE) begin
      prod_q <= prod_d;
    end
  end

  assign out_o.force_index = ema_q;
endmodule

[tb/force_index_ema_unit_check.sv]
`timescale 1ns / 100ps

module force_index_ema_unit_check (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  fie_in_if                          in_mon,
  fie_out_if                         out_mon,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fie_pkg::APB_AW-1:0] paddr,
  input  logic [fie_pkg::APB_DW-1:0] pwdata,
  input  logic                       pready,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);
  import fie_pkg::*;

  phase_e                     series_phase = PH_FIRST;
  logic [PRICE_W-1:0]         prior_close  = '0;
  logic signed [FORCE_W-1:0]  smoothed     = '0;
  logic [ALPHA_W-1:0]         smoothing    = ALPHA_RESET;
  logic signed [FORCE_W-1:0]  expected_force_q[$];

  // One bar of the series; updates the predicted state and yields the smoothed force.
  function automatic void advance_series(input logic [PRICE_W-1:0] close,
                                         input logic [VOL_W-1:0] volume,
                                         input logic last,
                                         output logic produced,
                                         output logic signed [FORCE_W-1:0] force_val);
    logic signed [DIFF_W-1:0]  diff;
    logic signed [FORCE_W-1:0] raw;
    logic signed [DELTA_W-1:0] delta;
    logic signed [PROD_W-1:0]  prod;
    logic [ALPHA_W-1:0]        weight;
    produced  = 1'b0;
    force_val = '0;
    if (series_phase == PH_FIRST) begin
      prior_close  = close;
      series_phase = PH_SEED;
    end else begin
      diff = $signed({1'b0, close}) - $signed({1'b0, prior_close});
      raw  = diff * $signed({1'b0, volume});
      if (series_phase == PH_SEED) begin
        smoothed     = raw;
        series_phase = PH_RUN;
      end else begin
        weight   = (smoothing > ALPHA_ONE) ? ALPHA_ONE : smoothing;
        delta    = raw - smoothed;
        prod     = delta * $signed({1'b0, weight});
        // floor division by 2^16 of an exact product
        smoothed = smoothed + (prod >>> FRAC_W);
      end
      prior_close = close;
      produced    = 1'b1;
      force_val   = smoothed;
    end
    if (last) begin
      series_phase = PH_FIRST;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    logic                      produced;
    logic signed [FORCE_W-1:0] predicted;
    logic signed [FORCE_W-1:0] oldest;
    if (!rst_ni) begin
      series_phase = PH_FIRST;
      prior_close  = '0;
      smoothed     = '0;
      smoothing    = ALPHA_RESET;
      expected_force_q.delete();
      fail_count_o = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[APB_AW-1:2] == REG_SMOOTHING) begin
        smoothing = pwdata[ALPHA_W-1:0];
      end
      if (in_mon.valid && in_mon.ready) begin
        advance_series(in_mon.close_price, in_mon.trade_volume, in_mon.last_of_series,
                       produced, predicted);
        if (produced) begin
          expected_force_q.push_back(predicted);
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (expected_force_q.size() == 0) begin
          $error("force_index: unexpected transaction, got %0d", out_mon.force_index);
          fail_count_o++;
        end else begin
          oldest = expected_force_q.pop_front();
          if (out_mon.force_index !== oldest) begin
            $error("force_index mismatch: expected %0d, got %0d",
                   oldest, out_mon.force_index);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = expected_force_q.size();
  end

endmodule

[tb/force_index_ema_unit_test.sv]
`timescale 1ns / 100ps

module force_index_ema_unit_test;
  import fie_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 300000;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned HOLD_CYCLES     = 150;
  localparam int unsigned HOLD_AFTER      = 200;
  localparam int unsigned ITEMS_PER_PHASE = 65;
  localparam int unsigned RANDOM_PHASES   = 8;
  localparam logic [PRICE_W-1:0] PRICE_MAX = '1;
  localparam logic [VOL_W-1:0]   VOL_MAX   = '1;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;
  bit          src_idle_on = 1'b1;
  bit          sink_idle_on = 1'b1;
  bit          sink_hold = 1'b0;

  fie_in_if  in_if();
  fie_out_if out_if();

  force_index_ema_unit i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  force_index_ema_unit_check i_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap(input bit enabled);
    int unsigned roll;
    roll = $urandom_range(99);
    if (!enabled || roll < 60) return 0;
    if (roll < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // result side: random stalls plus one long hold-off
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    out_if.ready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if ($urandom_range(199) == 0) sink_idle_on = !sink_idle_on;
      if (sink_hold) begin
        out_if.ready <= 1'b0;
      end else if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        stall_left = pick_gap(sink_idle_on);
        if (stall_left == 0) begin
          out_if.ready <= 1'b1;
        end else begin
          out_if.ready <= 1'b0;
          stall_left--;
        end
      end
    end
  end

  // long hold-off so the block fills up and backs up its input
  initial begin
    wait (items_sent >= HOLD_AFTER);
    @(posedge clk_i);
    sink_hold = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    sink_hold = 1'b0;
  end

  task automatic send_item(input logic [PRICE_W-1:0] close, input logic [VOL_W-1:0] volume,
                           input logic last);
    int unsigned gap;
    gap = pick_gap(src_idle_on);
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_if.valid          <= 1'b1;
    in_if.close_price    <= close;
    in_if.trade_volume   <= volume;
    in_if.last_of_series <= last;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    items_sent++;
    if ($urandom_range(39) == 0) src_idle_on = !src_idle_on;
  endtask

  // drop valid and let every expected transaction drain, plus the block's latency
  task automatic settle_block();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_smoothing(input logic [ALPHA_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_SMOOTHING, 2'b00};
    pwdata  <= APB_DW'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [PRICE_W-1:0] next_close(input logic [PRICE_W-1:0] prev);
    int unsigned roll;
    int          moved;
    roll = $urandom_range(99);
    if (roll < 30) return PRICE_W'($urandom());
    if (roll < 40) return ($urandom_range(1) == 1) ? PRICE_MAX : '0;
    moved = int'(prev) + int'($urandom_range(8192)) - 4096;
    if (moved < 0) moved = 0;
    if (moved > int'(PRICE_MAX)) moved = int'(PRICE_MAX);
    return PRICE_W'(moved);
  endfunction

  function automatic logic [VOL_W-1:0] pick_volume();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return VOL_W'($urandom());
    if (roll < 85) return VOL_W'($urandom_range(255));
    return ($urandom_range(1) == 1) ? VOL_MAX : '0;
  endfunction

  // series of random length; a few items get a random end marker, stray or missing
  task automatic random_series(input int unsigned count);
    int unsigned        done;
    int unsigned        len;
    int unsigned        roll;
    logic [PRICE_W-1:0] close;
    logic               last;
    done  = 0;
    close = PRICE_W'($urandom());
    while (done < count) begin
      roll = $urandom_range(99);
      if (roll < 10) len = 1;
      else if (roll < 20) len = 2;
      else if (roll < 80) len = $urandom_range(12, 3);
      else len = $urandom_range(40, 13);
      for (int unsigned k = 0; k < len && done < count; k++) begin
        close = next_close(close);
        last  = (k == len - 1);
        if ($urandom_range(19) == 0) last = 1'($urandom_range(1));
        send_item(close, pick_volume(), last);
        done++;
      end
    end
  endtask

  initial begin
    logic [ALPHA_W-1:0] alpha_plan [RANDOM_PHASES];
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_if.valid          = 1'b0;
    in_if.close_price    = '0;
    in_if.trade_volume   = '0;
    in_if.last_of_series = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset weight: extremes of price and volume, short series
    send_item('0, '0, 1'b0);
    send_item(PRICE_MAX, VOL_MAX, 1'b0);
    send_item('0, VOL_MAX, 1'b0);
    send_item(PRICE_MAX, '0, 1'b0);
    send_item(PRICE_MAX, VOL_MAX, 1'b1);
    send_item(24'h123456, 24'd1000, 1'b1);
    send_item(24'h000100, 24'd5, 1'b0);
    send_item(24'h000200, 24'd7, 1'b1);
    send_item(24'h800000, 24'h800000, 1'b0);
    send_item(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_item(24'hAAAAAA, 24'h555555, 1'b0);
    send_item(24'h555555, 24'hAAAAAA, 1'b1);

    // weight of exactly one: average tracks the raw force
    settle_block();
    write_smoothing(ALPHA_ONE);
    send_item(PRICE_MAX, 24'd1, 1'b0);
    send_item('0, VOL_MAX, 1'b0);
    send_item(PRICE_MAX, VOL_MAX, 1'b0);
    send_item('0, 24'h001234, 1'b1);

    // zero weight: average holds its seed
    settle_block();
    write_smoothing('0);
    send_item(24'h400000, VOL_MAX, 1'b0);
    send_item('0, VOL_MAX, 1'b0);
    send_item(PRICE_MAX, VOL_MAX, 1'b0);
    send_item('0, VOL_MAX, 1'b1);

    // weight above one gets clamped
    settle_block();
    write_smoothing('1);
    send_item('0, VOL_MAX, 1'b0);
    send_item(PRICE_MAX, VOL_MAX, 1'b0);
    send_item('0, VOL_MAX, 1'b0);
    send_item(PRICE_MAX, VOL_MAX, 1'b1);

    alpha_plan[0] = 17'd1;
    alpha_plan[1] = 17'd65535;
    alpha_plan[2] = ALPHA_W'($urandom_range(65536, 1));
    alpha_plan[3] = 17'd65537;
    alpha_plan[4] = ALPHA_RESET;
    alpha_plan[5] = ALPHA_W'($urandom());
    alpha_plan[6] = 17'd3;
    alpha_plan[7] = ALPHA_ONE;
    for (int unsigned p = 0; p < RANDOM_PHASES; p++) begin
      settle_block();
      write_smoothing(alpha_plan[p]);
      random_series(ITEMS_PER_PHASE);
    end

    settle_block();
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
